### rtl/bcld_pkg.sv
// Shared types and constants for the button click / long-press detector.
`default_nettype none
package bcld_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned MsW   = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE_MS = 2'd0,
    REG_CLICK_MS    = 2'd1,
    REG_PRESS_MS    = 2'd2,
    REG_ACTIVE_LOW  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  // Timing thresholds seen by the click state machine.
  typedef struct packed {
    logic [MsW-1:0] click_ms;
    logic [MsW-1:0] press_ms;
  } fsm_cfg_t;

endpackage
`default_nettype wire

### rtl/bcld_fsm.sv
// Click / double-click / long-press state machine on the debounced level.
`default_nettype none
module bcld_fsm (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step,
  input  wire logic                             pressed,
  input  wire logic [bcld_pkg::TimeW-1:0]       now,
  input  wire bcld_pkg::fsm_cfg_t               cfg,
  output bcld_pkg::event_t                      ev
);

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_DOWN     = 3'd1,
    S_UP       = 3'd2,
    S_COUNT    = 3'd3,
    S_HELD     = 3'd4,
    S_HELD_END = 3'd5
  } state_t;

  state_t                       state_r, state_nxt;
  logic [1:0]                   count_r, count_nxt;
  logic [bcld_pkg::TimeW-1:0]   start_r, start_nxt;
  logic [bcld_pkg::TimeW-1:0]   elapsed;

  assign elapsed = now - start_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    start_nxt = start_r;
    ev        = bcld_pkg::EV_NONE;
    case (state_r)
      S_IDLE: begin
        if (pressed) begin
          state_nxt = S_DOWN;
          start_nxt = now;
          count_nxt = 2'd0;
        end
      end
      S_DOWN: begin
        if (!pressed) begin
          state_nxt = S_UP;
          start_nxt = now;
        end else if (elapsed > {{(bcld_pkg::TimeW-bcld_pkg::MsW){1'b0}}, cfg.press_ms}) begin
          ev        = bcld_pkg::EV_LONG;
          state_nxt = S_HELD;
        end
      end
      S_UP: begin
        // saturate at three clicks
        if (count_r != 2'd3) count_nxt = count_r + 2'd1;
        state_nxt = S_COUNT;
      end
      S_COUNT: begin
        if (pressed) begin
          state_nxt = S_DOWN;
          start_nxt = now;
        end else if (elapsed >= {{(bcld_pkg::TimeW-bcld_pkg::MsW){1'b0}}, cfg.click_ms} ||
                     count_r == 2'd2) begin
          if (count_r == 2'd1)      ev = bcld_pkg::EV_CLICK;
          else if (count_r == 2'd2) ev = bcld_pkg::EV_DOUBLE;
          state_nxt = S_IDLE;
          count_nxt = 2'd0;
          start_nxt = '0;
        end
      end
      S_HELD: begin
        if (!pressed) begin
          state_nxt = S_HELD_END;
          start_nxt = now;
        end
      end
      S_HELD_END: begin
        state_nxt = S_IDLE;
        count_nxt = 2'd0;
        start_nxt = '0;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= 2'd0;
      start_r <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      start_r <= start_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/button_click_longpress_detector_core.sv
// Debounce the polled pin level, classify presses and register one result per poll.
// Latency: each poll's result is registered and shown in the cycle after its transfer.
// Throughput: one poll per cycle while no result is held by out_stall; the single result register sets the pace and
// takes a new result in the same cycle that the old one is taken.
// Reset (rst_n low, synchronous): state machine idle, debounce state cleared,
// registers back to debounce 50 ms, click 400 ms, press 800 ms, active low.
`default_nettype none
module button_click_longpress_detector_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [bcld_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [bcld_pkg::MsW-1:0]          cfg_wdata,
  // polls
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bcld_pkg::TimeW-1:0]        in_time_ms,
  input  wire logic                              in_pin_level,
  // results
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             out_event_res,
  output logic                                   out_stable_level
);

  logic [bcld_pkg::MsW-1:0]     debounce_ms_r;
  logic [bcld_pkg::MsW-1:0]     click_ms_r;
  logic [bcld_pkg::MsW-1:0]     press_ms_r;
  logic                         active_low_r;

  logic                         last_raw_r, last_raw_nxt;
  logic [bcld_pkg::TimeW-1:0]   last_change_r, last_change_nxt;
  logic                         deb_r, deb_nxt;

  logic                         out_valid_r;
  logic [1:0]                   out_event_r;
  logic                         out_level_r;

  logic                         in_xfer;
  logic                         level;
  logic [bcld_pkg::TimeW-1:0]   since_change;
  bcld_pkg::fsm_cfg_t           fsm_cfg;
  bcld_pkg::event_t             ev;

  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_event_res    = out_event_r;
  assign out_stable_level = out_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= 16'd50;
      click_ms_r    <= 16'd400;
      press_ms_r    <= 16'd800;
      active_low_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        bcld_pkg::REG_DEBOUNCE_MS: debounce_ms_r <= cfg_wdata;
        bcld_pkg::REG_CLICK_MS:    click_ms_r    <= cfg_wdata;
        bcld_pkg::REG_PRESS_MS:    press_ms_r    <= cfg_wdata;
        bcld_pkg::REG_ACTIVE_LOW:  active_low_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // debounce: follow the active level once it has held for debounce_ms
  assign level        = in_pin_level ^ active_low_r;
  assign since_change = in_time_ms - last_change_r;

  always_comb begin
    last_raw_nxt    = last_raw_r;
    last_change_nxt = last_change_r;
    deb_nxt         = deb_r;
    if (level == last_raw_r) begin
      if (since_change >= {{(bcld_pkg::TimeW-bcld_pkg::MsW){1'b0}}, debounce_ms_r})
        deb_nxt = level;
    end else begin
      last_change_nxt = in_time_ms;
      last_raw_nxt    = level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= 1'b0;
      last_change_r <= '0;
      deb_r         <= 1'b0;
    end else if (in_xfer) begin
      last_raw_r    <= last_raw_nxt;
      last_change_r <= last_change_nxt;
      deb_r         <= deb_nxt;
    end
  end

  assign fsm_cfg.click_ms = click_ms_r;
  assign fsm_cfg.press_ms = press_ms_r;

  bcld_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_xfer),
    .pressed (deb_nxt),
    .now     (in_time_ms),
    .cfg     (fsm_cfg),
    .ev      (ev)
  );

  // result register: load on input transfer, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_event_r <= ev;
      out_level_r <= deb_nxt;
    end
  end

endmodule
`default_nettype wire
